/* hdl/lbvs_pkg.sv */
package lbvs_pkg;

  localparam int FracBits   = 16;
  localparam int WeightBits = 16;
  localparam int MaxJoints  = 64;
  localparam int JointW     = 6;
  localparam int MatWords   = 12;
  localparam int MemDepth   = MaxJoints * MatWords;
  localparam int AddrW      = 10;
  localparam int DivW       = 32 + FracBits;
  localparam int SqrtSteps  = 32;
  localparam logic [6:0]  JointLimitRst = 7'd64;
  localparam logic [16:0] WeightMin     = 17'd7;
  localparam logic [63:0] LenEpsSq = (64'd1 << (2 * FracBits)) / 64'd100000000;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) return 32'sh7fffffff;
    else if (v < -53'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
    if (v > 53'sd140737488355327) return 48'sh7fffffffffff;
    else if (v < -53'sd140737488355328) return 48'sh800000000000;
    else return v[47:0];
  endfunction

endpackage

/* hdl/lbvs_mul.sv */
module lbvs_mul
  import lbvs_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* hdl/lbvs_iter.sv */
module lbvs_iter
  import lbvs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iter_req_t   req_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output iter_stat_t  stat_o,
  output logic [63:0] res_o
);

  logic [63:0] num_q, num_d;
  logic [65:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  iter_op_e    op_q, op_d;
  logic [65:0] rem_n, trial, diff;
  logic        ge;

  // one digit per cycle: two radicand bits for sqrt, one dividend bit for divide
  always_comb begin
    if (op_q == OP_SQRT) begin
      rem_n = {rem_q[63:0], num_q[63:62]};
      trial = {res_q, 2'b01};
    end else begin
      rem_n = {rem_q[64:0], num_q[63]};
      trial = {34'd0, den_i};
    end
    ge   = rem_n >= trial;
    diff = rem_n - trial;
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      res_d  = '0;
      if (req_i.op == OP_SQRT) begin
        num_d = num_i;
        cnt_d = 6'(SqrtSteps - 1);
      end else begin
        num_d = num_i;
        cnt_d = 6'(DivW - 1);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff : rem_n;
      res_d = {res_q[62:0], ge};
      num_d = (op_q == OP_SQRT) ? {num_q[61:0], 2'b00} : {num_q[62:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign res_o  = res_q;

endmodule

/* hdl/linear_blend_vertex_skinning.sv */
// Linear blend skinning with one shared 33x33 multiplier and one shared
// sqrt/divide digit unit. An influence runs, for each of three rows, a
// matrix read and the position and normal products per column, then the
// translation and the weighted position and normal updates; a skipped
// influence does no work. The last influence adds the squared length of
// the normal and the load of the output word, and when the normal is long
// enough a square root and three divisions, one result bit per cycle. The
// matrix store holds 64 joints of 12 Q16.16 words and must be loaded
// before any joint is used.
module linear_blend_vertex_skinning
  import lbvs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         joint_i,
  input  logic [3:0]         element_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] nrm_x_i,
  input  logic signed [31:0] nrm_y_i,
  input  logic signed [31:0] nrm_z_i,
  input  logic [16:0]        weight_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [31:0] out_nrm_x_o,
  output logic signed [31:0] out_nrm_y_o,
  output logic signed [31:0] out_nrm_z_o
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_RD   = 18'h00002,
    S_MP   = 18'h00004,
    S_MN   = 18'h00008,
    S_AN   = 18'h00010,
    S_RT   = 18'h00020,
    S_TR   = 18'h00040,
    S_WA   = 18'h00080,
    S_WP   = 18'h00100,
    S_WN   = 18'h00200,
    S_SQM  = 18'h00400,
    S_SQA  = 18'h00800,
    S_CMP  = 18'h01000,
    S_SQS  = 18'h02000,
    S_SQW  = 18'h04000,
    S_DVS  = 18'h08000,
    S_DVW  = 18'h10000,
    S_OUT  = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic [6:0] limit_q;
  logic       out_valid_q;

  logic [JointW-1:0]  joint_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] n_q [3];
  logic [16:0]        w_q;
  logic               last_q;
  logic [1:0]         row_q, col_q;
  logic signed [31:0] coef_q;
  logic signed [51:0] tp_q, tn_q;
  logic signed [31:0] tpc_q, tnc_q;
  logic signed [47:0] pos_acc_q [3];
  logic signed [47:0] nrm_acc_q [3];
  logic signed [31:0] nv_q [3];
  logic [63:0]        sumsq_q;
  logic [31:0]        len_q;
  logic signed [31:0] opos_q [3];
  logic signed [31:0] onrm_q [3];

  logic signed [31:0] mem [MemDepth];
  logic signed [31:0] rdata_q;
  logic [AddrW-1:0]   raddr, waddr, base;
  logic [3:0]         word;
  logic               wr_en;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [49:0] sh;

  iter_req_t          ireq;
  iter_stat_t         istat;
  logic [63:0]        inum, ires;

  logic               accept, skip, out_take, out_load;
  logic signed [31:0] nv_col, nv_sq;
  logic [32:0]        nv_abs;
  logic signed [52:0] qv;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == S_OUT) && !(out_valid_q && out_stall_i);
  assign sh       = prod[65:16];

  assign skip = (weight_i < WeightMin) || ({1'b0, joint_i} >= {2'b00, limit_q}) ||
                (joint_i[7:JointW] != '0);

  // matrix store
  assign base  = (AddrW'(joint_q) << 3) + (AddrW'(joint_q) << 2);
  assign word  = (state_q == S_RT) ? (4'd9 + {2'b00, row_q})
                                   : ({1'b0, col_q, 1'b0} + {2'b00, col_q} + {2'b00, row_q});
  assign raddr = base + AddrW'(word);
  assign waddr = (AddrW'(joint_i[JointW-1:0]) << 3) + (AddrW'(joint_i[JointW-1:0]) << 2) +
                 AddrW'(element_i);
  assign wr_en = accept && !func_i && (joint_i[7:JointW] == '0) &&
                 (element_i < 4'(MatWords));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= value_i;
    end
    rdata_q <= mem[raddr];
  end

  assign nv_sq  = sat32(53'(nrm_acc_q[col_q]));
  assign nv_col = nv_q[col_q];
  assign nv_abs = nv_col[31] ? (33'd0 - {nv_col[31], nv_col}) : {1'b0, nv_col};
  assign inum   = (state_q == S_DVS) ? {nv_abs[31:0], {FracBits{1'b0}}, {(64-DivW){1'b0}}}
                                     : sumsq_q;
  assign qv     = nv_col[31] ? (53'sd0 - $signed({5'd0, ires[DivW-1:0]}))
                             : $signed({5'd0, ires[DivW-1:0]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MP: begin
        mul_a = 33'(rdata_q);
        mul_b = 33'(p_q[col_q]);
      end
      S_MN: begin
        mul_a = 33'(coef_q);
        mul_b = 33'(n_q[col_q]);
      end
      S_WA: begin
        mul_a = 33'(tpc_q);
        mul_b = $signed({16'd0, w_q});
      end
      S_WP: begin
        mul_a = 33'(tnc_q);
        mul_b = $signed({16'd0, w_q});
      end
      S_SQM: begin
        mul_a = 33'(nv_sq);
        mul_b = 33'(nv_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lbvs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    ireq.start = (state_q == S_SQS) || (state_q == S_DVS);
    ireq.op    = (state_q == S_DVS) ? OP_DIV : OP_SQRT;
  end

  lbvs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ireq),
    .num_i  (inum),
    .den_i  (len_q),
    .stat_o (istat),
    .res_o  (ires)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && func_i) begin
          if (!skip) state_d = S_RD;
          else if (last_i) state_d = S_SQM;
        end
      end
      S_RD:  state_d = S_MP;
      S_MP:  state_d = S_MN;
      S_MN:  state_d = S_AN;
      S_AN:  state_d = (col_q == 2'd2) ? S_RT : S_RD;
      S_RT:  state_d = S_TR;
      S_TR:  state_d = S_WA;
      S_WA:  state_d = S_WP;
      S_WP:  state_d = S_WN;
      S_WN: begin
        if (row_q != 2'd2) state_d = S_RD;
        else state_d = last_q ? S_SQM : S_IDLE;
      end
      S_SQM: state_d = S_SQA;
      S_SQA: state_d = (col_q == 2'd2) ? S_CMP : S_SQM;
      S_CMP: state_d = (sumsq_q > LenEpsSq) ? S_SQS : S_OUT;
      S_SQS: state_d = S_SQW;
      S_SQW: if (istat.done) state_d = S_DVS;
      S_DVS: state_d = S_DVW;
      S_DVW: if (istat.done) state_d = (col_q == 2'd2) ? S_OUT : S_DVS;
      S_OUT: if (!(out_valid_q && out_stall_i)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= JointLimitRst;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_acc_q[i] <= '0;
        nrm_acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      // a new word loads while the old one leaves
      if (out_load) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          row_q <= '0;
          col_q <= '0;
        end
        S_AN:  col_q <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
        S_WP:  pos_acc_q[row_q] <= sat48(53'(pos_acc_q[row_q]) + 53'(sh));
        S_WN: begin
          nrm_acc_q[row_q] <= sat48(53'(nrm_acc_q[row_q]) + 53'(sh));
          row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
          col_q <= '0;
        end
        S_SQA: col_q <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
        S_DVW: if (istat.done) col_q <= (col_q == 2'd2) ? 2'd0 : col_q + 2'd1;
        S_OUT: begin
          if (!(out_valid_q && out_stall_i)) begin
            for (int i = 0; i < 3; i++) begin
              pos_acc_q[i] <= '0;
              nrm_acc_q[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          joint_q <= joint_i[JointW-1:0];
          p_q[0]  <= pos_x_i;
          p_q[1]  <= pos_y_i;
          p_q[2]  <= pos_z_i;
          n_q[0]  <= nrm_x_i;
          n_q[1]  <= nrm_y_i;
          n_q[2]  <= nrm_z_i;
          w_q     <= weight_i;
          last_q  <= last_i;
        end
        tp_q    <= '0;
        tn_q    <= '0;
        sumsq_q <= '0;
      end
      S_MP: coef_q <= rdata_q;
      S_MN: tp_q <= tp_q + 52'(sh);
      S_AN: tn_q <= tn_q + 52'(sh);
      S_TR: begin
        tpc_q <= sat32(53'(tp_q) + 53'(rdata_q));
        tnc_q <= sat32(53'(tn_q));
      end
      S_WN: begin
        tp_q    <= '0;
        tn_q    <= '0;
        sumsq_q <= '0;
      end
      S_SQM: nv_q[col_q] <= nv_sq;
      S_SQA: sumsq_q <= sumsq_q + prod[63:0];
      S_SQW: if (istat.done) len_q <= ires[31:0];
      S_DVW: if (istat.done) nv_q[col_q] <= sat32(qv);
      S_OUT: begin
        if (!(out_valid_q && out_stall_i)) begin
          for (int i = 0; i < 3; i++) begin
            opos_q[i] <= sat32(53'(pos_acc_q[i]));
            onrm_q[i] <= nv_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_x_o = opos_q[0];
  assign out_pos_y_o = opos_q[1];
  assign out_pos_z_o = opos_q[2];
  assign out_nrm_x_o = onrm_q[0];
  assign out_nrm_y_o = onrm_q[1];
  assign out_nrm_z_o = onrm_q[2];

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !(out_valid_q && out_stall_i) |=>
      out_valid_q && (pos_acc_q[0] == '0) && (nrm_acc_q[2] == '0))
    else $error("accumulators not cleared after word emitted");

  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !istat.busy)
    else $error("sqrt/divide unit busy while idle");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DVS) |-> (len_q != '0))
    else $error("divide by zero length");

endmodule
